// ===== hw/rtl/planar_odometry_integrator_top_defines.svh =====
// Assertion macros for the planar odometry integrator.
// Included by planar_odometry_integrator_top.sv; depends on nothing else.
`ifndef PLANAR_ODOMETRY_INTEGRATOR_TOP_DEFINES_SVH
`define PLANAR_ODOMETRY_INTEGRATOR_TOP_DEFINES_SVH

// same-cycle implication, disabled while reset is low
`define POI_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("odometry integrator: same-cycle check failed");

// next-cycle implication, disabled while reset is low
`define POI_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("odometry integrator: next-cycle check failed");

`endif

// ===== hw/rtl/poi_pkg.sv =====
// Types and fixed-point constants of the planar odometry integrator.
// No dependencies; used by planar_odometry_integrator_top.
package poi_pkg;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_TRIG,
        ST_QUAD,
        ST_MULA,
        ST_MID,
        ST_MULB,
        ST_POST
    } t_state;

    // quadrant codes from the top two bits of the 32-bit angle
    localparam logic [1:0] QUAD_0 = 2'd0;
    localparam logic [1:0] QUAD_1 = 2'd1;
    localparam logic [1:0] QUAD_2 = 2'd2;
    localparam logic [1:0] QUAD_3 = 2'd3;

    localparam int IN_W     = 24;   // velocity and time fields
    localparam int CORDIC_W = 32;   // Q2.30 vector, residual angle in 32-bit angle units
    localparam int XY_ACC_W = 58;   // v*cos and p*dt products
    localparam int P_SHIFT  = 30;
    localparam int P_W      = XY_ACC_W - P_SHIFT;
    localparam int DX_SHIFT = 20;
    localparam int DX_W     = 32;
    localparam int TURN_W   = 68;   // w*K*dt kept modulo 2^68

    localparam logic signed [CORDIC_W-1:0] CORDIC_INIT  = 32'sd652032874;
    localparam logic [29:0]                RAD_TO_ANGLE = 30'd683565276;

    // atan(2^-i) in 32-bit angle units
    localparam logic [31:0] ATAN_TAB [0:31] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
        32'd42667331,  32'd21354465,  32'd10680862,  32'd5340245,
        32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
        32'd166886,    32'd83443,     32'd41722,     32'd20861,
        32'd10430,     32'd5215,      32'd2608,      32'd1304,
        32'd652,       32'd326,       32'd163,       32'd81,
        32'd41,        32'd20,        32'd10,        32'd5,
        32'd3,         32'd1,         32'd1,         32'd0
    };

endpackage

// ===== hw/rtl/planar_odometry_integrator_top.sv =====
// Planar odometry integrator: CORDIC heading trig, bit-serial products, pose accumulators.
// Depends on poi_pkg and planar_odometry_integrator_top_defines.svh.
//
// Channel  Dir  Handshake                  Payload
// request  in   i_in_valid / o_in_stall    i_lin_vel, i_ang_vel, i_elapsed_time
// pose     out  o_out_valid / i_out_stall  o_pos_x, o_pos_y, o_heading
//
// A request runs from accept to the next accept as TRIG_STEPS (max 32) CORDIC
// steps, one per cycle, then two passes of the 24-bit bit-serial multiply
// lanes (one multiplier bit per cycle: v and w first, then dt), plus the
// accept, quadrant fold, lane reload and pose write states.
// Reset (synchronous, active low) zeroes the pose and returns to idle.
// The pose registers are the output register; a new request is taken while a
// result waits, and only the final pose write waits for the result to drain.
`include "planar_odometry_integrator_top_defines.svh"

module planar_odometry_integrator_top #(
    parameter int POS_BITS   = 40,
    parameter int ANGLE_BITS = 32,
    parameter int TRIG_STEPS = 24
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  logic signed [23:0]           i_lin_vel,
    input  logic signed [23:0]           i_ang_vel,
    input  logic        [23:0]           i_elapsed_time,
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output logic signed [POS_BITS-1:0]   o_pos_x,
    output logic signed [POS_BITS-1:0]   o_pos_y,
    output logic        [ANGLE_BITS-1:0] o_heading
);

    localparam int IN_W     = poi_pkg::IN_W;
    localparam int CW       = poi_pkg::CORDIC_W;
    localparam int XW       = poi_pkg::XY_ACC_W;
    localparam int TW       = poi_pkg::TURN_W;
    localparam int P_W      = poi_pkg::P_W;
    localparam int DX_W     = poi_pkg::DX_W;
    localparam int P_SHIFT  = poi_pkg::P_SHIFT;
    localparam int DX_SHIFT = poi_pkg::DX_SHIFT;
    localparam int CORDIC_N = (TRIG_STEPS < 32) ? TRIG_STEPS : 32;
    localparam int SUM_W    = ((POS_BITS > DX_W) ? POS_BITS : DX_W) + 1;

    localparam logic [4:0]    TRIG_LAST = 5'(CORDIC_N - 1);
    localparam logic [4:0]    IN_LAST   = 5'(IN_W - 1);
    localparam logic [XW-1:0] P_HALF    = XW'(1) << (P_SHIFT - 1);
    localparam logic [XW-1:0] DX_HALF   = XW'(1) << (DX_SHIFT - 1);
    localparam logic [TW-1:0] TURN_HALF = TW'(1) << (TW - ANGLE_BITS - 1);
    localparam logic signed [SUM_W-1:0] POS_HI = (SUM_W'(1) << (POS_BITS - 1)) - SUM_W'(1);
    localparam logic signed [SUM_W-1:0] POS_LO = -POS_HI - SUM_W'(1);

    poi_pkg::t_state r_state, n_state;
    logic [4:0]      r_cnt;
    logic            r_out_valid;

    logic signed [POS_BITS-1:0] r_x, r_y;
    logic [ANGLE_BITS-1:0]      r_heading;

    logic signed [CW-1:0] r_cx, r_cy, r_cz;
    logic [IN_W-1:0]      r_mul_v, r_mul_w, r_dt;
    logic [XW-1:0]        r_mc_x, r_mc_y, r_acc_x, r_acc_y;
    logic [TW-1:0]        r_mc_t, r_acc_t;

    logic c_idle, c_trig, c_quad, c_mul_a, c_mul_b, c_mid, c_post;
    logic accept, out_free, post_write, mul_sub, cnt_trig_last, cnt_mul_last;

    // ---------------- control ----------------
    assign cnt_trig_last = (r_cnt == TRIG_LAST);
    assign cnt_mul_last  = (r_cnt == IN_LAST);
    assign out_free      = !r_out_valid || !i_out_stall;
    assign accept        = c_idle && i_in_valid;
    assign post_write    = c_post && out_free;
    assign mul_sub       = c_mul_a && cnt_mul_last;   // sign bit of v and w weighs negative

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            poi_pkg::ST_IDLE: if (i_in_valid)    n_state = poi_pkg::ST_TRIG;
            poi_pkg::ST_TRIG: if (cnt_trig_last) n_state = poi_pkg::ST_QUAD;
            poi_pkg::ST_QUAD:                    n_state = poi_pkg::ST_MULA;
            poi_pkg::ST_MULA: if (cnt_mul_last)  n_state = poi_pkg::ST_MID;
            poi_pkg::ST_MID:                     n_state = poi_pkg::ST_MULB;
            poi_pkg::ST_MULB: if (cnt_mul_last)  n_state = poi_pkg::ST_POST;
            poi_pkg::ST_POST: if (out_free)      n_state = poi_pkg::ST_IDLE;
            default:                             n_state = poi_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        c_idle  = 1'b0;
        c_trig  = 1'b0;
        c_quad  = 1'b0;
        c_mul_a = 1'b0;
        c_mid   = 1'b0;
        c_mul_b = 1'b0;
        c_post  = 1'b0;
        unique case (r_state)
            poi_pkg::ST_IDLE: c_idle  = 1'b1;
            poi_pkg::ST_TRIG: c_trig  = 1'b1;
            poi_pkg::ST_QUAD: c_quad  = 1'b1;
            poi_pkg::ST_MULA: c_mul_a = 1'b1;
            poi_pkg::ST_MID:  c_mid   = 1'b1;
            poi_pkg::ST_MULB: c_mul_b = 1'b1;
            poi_pkg::ST_POST: c_post  = 1'b1;
            default:          c_idle  = 1'b0;
        endcase
    end

    assign o_in_stall  = !c_idle;
    assign o_out_valid = r_out_valid;
    assign o_pos_x     = r_x;
    assign o_pos_y     = r_y;
    assign o_heading   = r_heading;

    // ---------------- CORDIC step ----------------
    logic [31:0]          ang32;
    logic signed [CW-1:0] cx_sh, cy_sh, n_cx, n_cy, n_cz, atan_i, cos_q, sin_q;

    assign ang32  = 32'(r_heading) << (32 - ANGLE_BITS);
    assign cx_sh  = r_cx >>> r_cnt;
    assign cy_sh  = r_cy >>> r_cnt;
    assign atan_i = signed'(poi_pkg::ATAN_TAB[r_cnt]);

    always_comb begin
        if (!r_cz[CW-1]) begin
            n_cx = r_cx - cy_sh;
            n_cy = r_cy + cx_sh;
            n_cz = r_cz - atan_i;
        end else begin
            n_cx = r_cx + cy_sh;
            n_cy = r_cy - cx_sh;
            n_cz = r_cz + atan_i;
        end
    end

    always_comb begin
        unique case (ang32[31:30])
            poi_pkg::QUAD_0: begin cos_q = r_cx;  sin_q = r_cy;  end
            poi_pkg::QUAD_1: begin cos_q = -r_cy; sin_q = r_cx;  end
            poi_pkg::QUAD_2: begin cos_q = -r_cx; sin_q = -r_cy; end
            poi_pkg::QUAD_3: begin cos_q = r_cy;  sin_q = -r_cx; end
            default:         begin cos_q = r_cx;  sin_q = r_cy;  end
        endcase
    end

    // ---------------- serial multiply lanes ----------------
    logic [XW-1:0] add_x, add_y, n_acc_x, n_acc_y;
    logic [TW-1:0] add_t, n_acc_t;
    logic          sub_v, sub_w;

    assign sub_v   = mul_sub & r_mul_v[0];
    assign sub_w   = mul_sub & r_mul_w[0];
    assign add_x   = r_mul_v[0] ? (r_mc_x ^ {XW{mul_sub}}) : '0;
    assign add_y   = r_mul_v[0] ? (r_mc_y ^ {XW{mul_sub}}) : '0;
    assign add_t   = r_mul_w[0] ? (r_mc_t ^ {TW{mul_sub}}) : '0;
    assign n_acc_x = r_acc_x + add_x + XW'(sub_v);
    assign n_acc_y = r_acc_y + add_y + XW'(sub_v);
    assign n_acc_t = r_acc_t + add_t + TW'(sub_w);

    // rounded quotients: add half, then floor
    logic [XW-1:0]          rnd_px, rnd_py, rnd_dx, rnd_dy;
    logic [TW-1:0]          rnd_t;
    logic signed [P_W-1:0]  p_x, p_y;
    logic signed [DX_W-1:0] dx, dy;
    logic [ANGLE_BITS-1:0]  dth;

    assign rnd_px = r_acc_x + P_HALF;
    assign rnd_py = r_acc_y + P_HALF;
    assign rnd_dx = r_acc_x + DX_HALF;
    assign rnd_dy = r_acc_y + DX_HALF;
    assign rnd_t  = r_acc_t + TURN_HALF;
    assign p_x    = rnd_px[XW-1:P_SHIFT];
    assign p_y    = rnd_py[XW-1:P_SHIFT];
    assign dx     = rnd_dx[DX_SHIFT+DX_W-1:DX_SHIFT];
    assign dy     = rnd_dy[DX_SHIFT+DX_W-1:DX_SHIFT];
    assign dth    = rnd_t[TW-1 -: ANGLE_BITS];

    // ---------------- saturating pose update ----------------
    logic signed [SUM_W-1:0]    sum_x, sum_y;
    logic signed [POS_BITS-1:0] n_x, n_y;

    assign sum_x = SUM_W'(r_x) + SUM_W'(dx);
    assign sum_y = SUM_W'(r_y) + SUM_W'(dy);

    always_comb begin
        priority if (sum_x > POS_HI) n_x = POS_HI[POS_BITS-1:0];
        else if (sum_x < POS_LO)     n_x = POS_LO[POS_BITS-1:0];
        else                         n_x = sum_x[POS_BITS-1:0];
        priority if (sum_y > POS_HI) n_y = POS_HI[POS_BITS-1:0];
        else if (sum_y < POS_LO)     n_y = POS_LO[POS_BITS-1:0];
        else                         n_y = sum_y[POS_BITS-1:0];
    end

    // ---------------- registers ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= poi_pkg::ST_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
            r_x         <= '0;
            r_y         <= '0;
            r_heading   <= '0;
        end else begin
            r_state <= n_state;
            if (accept || c_quad || c_mid) begin
                r_cnt <= '0;
            end else if (c_trig || c_mul_a || c_mul_b) begin
                r_cnt <= r_cnt + 5'd1;
            end
            if (post_write) begin
                r_out_valid <= 1'b1;
                r_x         <= n_x;
                r_y         <= n_y;
                r_heading   <= r_heading + dth;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cx    <= poi_pkg::CORDIC_INIT;
            r_cy    <= '0;
            r_cz    <= {2'b00, ang32[29:0]};
            r_mul_v <= i_lin_vel;
            r_mul_w <= i_ang_vel;
            r_dt    <= i_elapsed_time;
        end
        if (c_trig) begin
            r_cx <= n_cx;
            r_cy <= n_cy;
            r_cz <= n_cz;
        end
        if (c_quad) begin
            r_mc_x  <= XW'(cos_q);
            r_mc_y  <= XW'(sin_q);
            r_mc_t  <= TW'(poi_pkg::RAD_TO_ANGLE);
            r_acc_x <= '0;
            r_acc_y <= '0;
            r_acc_t <= '0;
        end
        if (c_mid) begin
            r_mc_x  <= XW'(p_x);
            r_mc_y  <= XW'(p_y);
            r_mc_t  <= r_acc_t;
            r_acc_x <= '0;
            r_acc_y <= '0;
            r_acc_t <= '0;
            r_mul_v <= r_dt;
            r_mul_w <= r_dt;
        end
        if (c_mul_a || c_mul_b) begin
            r_acc_x <= n_acc_x;
            r_acc_y <= n_acc_y;
            r_acc_t <= n_acc_t;
            r_mc_x  <= r_mc_x << 1;
            r_mc_y  <= r_mc_y << 1;
            r_mc_t  <= r_mc_t << 1;
            r_mul_v <= r_mul_v >> 1;
            r_mul_w <= r_mul_w >> 1;
        end
    end

    // ---------------- checks ----------------
    `POI_ASSERT_NXT(a_accept_starts_trig, i_clk, i_rst_n, accept,
                    r_state == poi_pkg::ST_TRIG && r_cnt == '0)
    `POI_ASSERT_NXT(a_post_shows_pose, i_clk, i_rst_n, post_write,
                    r_out_valid && r_state == poi_pkg::ST_IDLE)
    `POI_ASSERT_IMP(a_dt_lanes_agree, i_clk, i_rst_n, r_state == poi_pkg::ST_MULB,
                    r_mul_v == r_mul_w)

endmodule
